FILE: sv/header_name_table_match_unit_macros.svh
// assertion macros for the header name table match unit
// used by the top level only; expects a clock and an active-low reset argument
`ifndef HEADER_NAME_TABLE_MATCH_UNIT_MACROS_SVH
`define HEADER_NAME_TABLE_MATCH_UNIT_MACROS_SVH

// same-cycle implication
`define HNTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HNTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hntm_pkg.sv
// shared types, constants and the case-insensitive byte compare
// no dependencies
package hntm_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned POS_W  = 5;

  localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;
  localparam logic [BYTE_W-1:0] LOWER_A  = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z  = 8'h7a;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_SCAN,
    SW_DRAIN
  } sweep_state_e;

  // accepted query byte handed to the sweep
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] name_byte;
    logic              last;
  } query_req_t;

  // sweep status and result
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } sweep_stat_t;

  // query byte q equals table byte t, ignoring case only where t is a lowercase letter
  function automatic logic byte_eq_ci(input logic [BYTE_W-1:0] q,
                                      input logic [BYTE_W-1:0] t);
    logic flip_eq;
    logic is_lower;
    flip_eq  = ((q ^ CASE_BIT) == t);
    is_lower = (t >= LOWER_A) && (t <= LOWER_Z);
    return (q == t) || (flip_eq && is_lower);
  endfunction

endpackage

FILE: sv/header_name_table_match_unit.sv
// top level of the header name table match unit: command port, table rams
// depends on hntm_pkg, hntm_ram, hntm_sweep and header_name_table_match_unit_macros.svh
//
//   channel   | handshake              | payload
//   ----------+------------------------+----------------------------------------------
//   request   | start, busy            | operation_i entry_slot_i byte_pos_i
//             |                        | name_byte_i last_byte_i
//   result    | done_o (one cycle)     | hit_o match_slot_o
//
// a load request writes the table byte and length rams directly
// a query byte makes one ram read per entry through the shared byte ram read port,
// then waits in the drain state for the last read to return
// a query byte past MAX_LEN is taken without a sweep; done_o follows the sweep of the final
// byte, or rises in the cycle after the final byte is taken when that byte is past MAX_LEN
// reset empties every entry at once through per-entry length valid flops; no clearing pass
// results cannot be stalled; busy is high only while a sweep is in progress
`include "header_name_table_match_unit_macros.svh"

module header_name_table_match_unit #(
  parameter int unsigned NUM_ENTRIES = 64,
  parameter int unsigned MAX_LEN     = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [hntm_pkg::SLOT_W-1:0]   entry_slot_i,
  input  logic [hntm_pkg::POS_W-1:0]    byte_pos_i,
  input  logic [hntm_pkg::BYTE_W-1:0]   name_byte_i,
  input  logic                          last_byte_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [hntm_pkg::SLOT_W-1:0]   match_slot_o
);

  localparam int unsigned EW = $clog2(NUM_ENTRIES);
  localparam int unsigned AW = $clog2(NUM_ENTRIES*MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN+1);

  logic                        accept;
  logic                        load_ok;
  logic [AW-1:0]               wr_addr;
  logic [EW-1:0]               wr_entry;
  logic [LW-1:0]               wr_len;
  logic [EW-1:0]               rd_entry;
  logic [AW-1:0]               rd_addr;
  logic [hntm_pkg::BYTE_W-1:0] rd_byte;
  logic [LW-1:0]               rd_len_raw;
  logic [LW-1:0]               rd_len;
  logic [NUM_ENTRIES-1:0]      len_vld_q;
  logic                        len_vld_rd_q;
  hntm_pkg::query_req_t        req;
  hntm_pkg::sweep_stat_t       stat;

  // request decode; loads outside the table are dropped
  assign accept   = start && !busy;
  assign load_ok  = accept && (operation_i == hntm_pkg::OP_LOAD) &&
                    (32'(entry_slot_i) < NUM_ENTRIES) && (32'(byte_pos_i) < MAX_LEN);
  assign wr_entry = EW'(entry_slot_i);
  assign wr_addr  = AW'(32'(entry_slot_i) * MAX_LEN + 32'(byte_pos_i));
  assign wr_len   = LW'(32'(byte_pos_i) + 1);

  assign req.valid     = accept && (operation_i == hntm_pkg::OP_QUERY);
  assign req.name_byte = name_byte_i;
  assign req.last      = last_byte_i;

  // keyword byte table
  hntm_ram #(
    .WIDTH (hntm_pkg::BYTE_W),
    .DEPTH (NUM_ENTRIES*MAX_LEN)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (wr_addr),
    .wdata_i (name_byte_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_byte)
  );

  // keyword length table
  hntm_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_ENTRIES)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok && last_byte_i),
    .waddr_i (wr_entry),
    .wdata_i (wr_len),
    .raddr_i (rd_entry),
    .rdata_o (rd_len_raw)
  );

  // length valid flops, an entry without a length reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q    <= '0;
      len_vld_rd_q <= 1'b0;
    end else begin
      if (load_ok && last_byte_i) begin
        len_vld_q[wr_entry] <= 1'b1;
      end
      len_vld_rd_q <= len_vld_q[rd_entry];
    end
  end

  assign rd_len = len_vld_rd_q ? rd_len_raw : '0;

  // entry sweep
  hntm_sweep #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_LEN     (MAX_LEN)
  ) u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rd_entry_o (rd_entry),
    .rd_addr_o  (rd_addr),
    .len_i      (rd_len),
    .byte_i     (rd_byte),
    .stat_o     (stat)
  );

  assign busy         = stat.busy;
  assign done_o       = stat.done;
  assign hit_o        = stat.hit;
  assign match_slot_o = stat.slot;

  // checks
  `HNTM_ASSERT_IMP(a_miss_slot_zero, clk_i, rst_ni, done_o && !hit_o,
                   match_slot_o == '0, "miss with nonzero slot")
  `HNTM_ASSERT_NXT(a_load_no_result, clk_i, rst_ni,
                   accept && (operation_i == hntm_pkg::OP_LOAD),
                   !done_o, "result after a load request")
  `HNTM_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy,
                   "result while sweep still busy")

endmodule

FILE: sv/hntm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hntm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/hntm_sweep.sv
// per-byte sweep over all table entries: issues ram reads, updates alive mask
// depends on hntm_pkg
module hntm_sweep #(
  parameter int unsigned NUM_ENTRIES = 64,
  parameter int unsigned MAX_LEN     = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  hntm_pkg::query_req_t                    req_i,
  output logic [$clog2(NUM_ENTRIES)-1:0]          rd_entry_o,
  output logic [$clog2(NUM_ENTRIES*MAX_LEN)-1:0]  rd_addr_o,
  input  logic [$clog2(MAX_LEN+1)-1:0]            len_i,
  input  logic [hntm_pkg::BYTE_W-1:0]             byte_i,
  output hntm_pkg::sweep_stat_t                   stat_o
);

  localparam int unsigned EW = $clog2(NUM_ENTRIES);
  localparam int unsigned AW = $clog2(NUM_ENTRIES*MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN+1);
  localparam logic [EW-1:0] LAST_ENTRY = EW'(NUM_ENTRIES-1);
  localparam logic [LW-1:0] POS_SAT    = LW'(MAX_LEN);
  localparam logic [AW-1:0] ROW_STEP   = AW'(MAX_LEN);

  hntm_pkg::sweep_state_e state_q, state_d;

  logic [LW-1:0]                 pos_q, pos_d;
  logic [NUM_ENTRIES-1:0]        alive_q, alive_d;
  logic [EW-1:0]                 iss_q, iss_d;
  logic [AW-1:0]                 addr_q, addr_d;
  logic                          eval_v_q, eval_v_d;
  logic                          eval_last_q, eval_last_d;
  logic [EW-1:0]                 eval_e_q, eval_e_d;
  logic [hntm_pkg::BYTE_W-1:0]   byte_q, byte_d;
  logic                          last_q, last_d;
  logic                          found_q, found_d;
  logic [EW-1:0]                 found_e_q, found_e_d;
  logic                          done_q, done_d;
  logic                          hit_q, hit_d;
  logic [hntm_pkg::SLOT_W-1:0]   slot_q, slot_d;

  logic          keep;
  logic          len_eq;
  logic [LW-1:0] pos_inc;

  // compare of the entry whose read data is back this cycle
  assign pos_inc = pos_q + LW'(1);
  assign keep    = alive_q[eval_e_q] && (pos_q < len_i) &&
                   hntm_pkg::byte_eq_ci(byte_q, byte_i);
  assign len_eq  = (len_i == pos_inc);

  // next state and sweep control
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    alive_d     = alive_q;
    iss_d       = iss_q;
    addr_d      = addr_q;
    byte_d      = byte_q;
    last_d      = last_q;
    found_d     = found_q;
    found_e_d   = found_e_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    slot_d      = slot_q;
    eval_v_d    = (state_q == hntm_pkg::SW_SCAN);
    eval_last_d = (state_q == hntm_pkg::SW_SCAN) && (iss_q == LAST_ENTRY);
    eval_e_d    = iss_q;

    case (state_q)
      hntm_pkg::SW_IDLE: begin
        if (req_i.valid) begin
          if (pos_q == POS_SAT) begin
            // overlong name: everything drops out, no compares
            alive_d = '0;
            if (req_i.last) begin
              done_d  = 1'b1;
              hit_d   = 1'b0;
              slot_d  = '0;
              pos_d   = '0;
              alive_d = '1;
            end
          end else begin
            byte_d  = req_i.name_byte;
            last_d  = req_i.last;
            iss_d   = '0;
            addr_d  = AW'(pos_q);
            found_d = 1'b0;
            state_d = hntm_pkg::SW_SCAN;
          end
        end
      end
      hntm_pkg::SW_SCAN: begin
        iss_d  = iss_q + EW'(1);
        addr_d = addr_q + ROW_STEP;
        if (iss_q == LAST_ENTRY) begin
          state_d = hntm_pkg::SW_DRAIN;
        end
      end
      hntm_pkg::SW_DRAIN: begin
        state_d = hntm_pkg::SW_IDLE;
      end
      default: begin
        state_d = hntm_pkg::SW_IDLE;
      end
    endcase

    // alive update and lowest exact-length hit
    if (eval_v_q) begin
      alive_d[eval_e_q] = keep;
      if (last_q && keep && len_eq && !found_q) begin
        found_d   = 1'b1;
        found_e_d = eval_e_q;
      end
      if (eval_last_q) begin
        pos_d = pos_inc;
        if (last_q) begin
          done_d  = 1'b1;
          hit_d   = found_d;
          slot_d  = found_d ? hntm_pkg::SLOT_W'(found_e_d) : '0;
          pos_d   = '0;
          alive_d = '1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hntm_pkg::SW_IDLE;
      pos_q       <= '0;
      alive_q     <= '1;
      iss_q       <= '0;
      addr_q      <= '0;
      eval_v_q    <= 1'b0;
      eval_last_q <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      alive_q     <= alive_d;
      iss_q       <= iss_d;
      addr_q      <= addr_d;
      eval_v_q    <= eval_v_d;
      eval_last_q <= eval_last_d;
      found_q     <= found_d;
      done_q      <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    eval_e_q  <= eval_e_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
    found_e_q <= found_e_d;
    hit_q     <= hit_d;
    slot_q    <= slot_d;
  end

  assign rd_entry_o  = iss_q;
  assign rd_addr_o   = addr_q;
  assign stat_o.busy = (state_q != hntm_pkg::SW_IDLE);
  assign stat_o.done = done_q;
  assign stat_o.hit  = hit_q;
  assign stat_o.slot = slot_q;

endmodule

FILE: verif/tb.sv
// self-checking testbench for header_name_table_match_unit
// depends on hntm_pkg and the unit itself; loads keywords, streams names, checks every result
module tb;

  localparam int NUM_ENTRIES    = 64;
  localparam int MAX_LEN        = 32;
  localparam int TARGET_ITEMS   = 450;
  localparam int CALM_AFTER     = 380;
  localparam int DRAIN_CYCLES   = NUM_ENTRIES + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_ROWS       = 26;

  typedef struct packed {
    logic                        hit;
    logic [hntm_pkg::SLOT_W-1:0] slot;
  } match_result_t;

  // one directed request; rep repeats it, pinned rows carry a typed-in result
  typedef struct packed {
    logic                        op;
    logic [hntm_pkg::SLOT_W-1:0] slot;
    logic [hntm_pkg::POS_W-1:0]  pos;
    logic [hntm_pkg::BYTE_W-1:0] nbyte;
    logic                        last;
    logic [5:0]                  rep;
    logic                        pinned;
    logic                        exp_hit;
    logic [hntm_pkg::SLOT_W-1:0] exp_slot;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // empty table right after reset
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "x",   1'b1, 6'd1,  1'b1, 1'b0, 6'd0},
    // same keyword in two slots, lower slot wins
    '{hntm_pkg::OP_LOAD,  6'd5,  5'd0,  "a",   1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_LOAD,  6'd5,  5'd1,  "b",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_LOAD,  6'd2,  5'd0,  "a",   1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_LOAD,  6'd2,  5'd1,  "b",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd63, 5'd31, "A",   1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "b",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    // top slot
    '{hntm_pkg::OP_LOAD,  6'd63, 5'd0,  "z",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "Z",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    // upper-case table byte only matches itself
    '{hntm_pkg::OP_LOAD,  6'd0,  5'd0,  8'h41, 1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  8'h61, 1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  8'h41, 1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    // non-letter differing in the case bit is a miss
    '{hntm_pkg::OP_LOAD,  6'd1,  5'd0,  8'h00, 1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  8'h20, 1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  8'h00, 1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    // top position and byte without setting a length
    '{hntm_pkg::OP_LOAD,  6'd63, 5'd31, 8'hff, 1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    // name shorter than the entry
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "a",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    // name running past the entry end
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "a",   1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "b",   1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "c",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    // table load in the middle of a name
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "q",   1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_LOAD,  6'd4,  5'd0,  "q",   1'b0, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_LOAD,  6'd4,  5'd1,  "r",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "R",   1'b1, 6'd1,  1'b0, 1'b0, 6'd0},
    // overlong name always misses
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "a",   1'b0, 6'd33, 1'b0, 1'b0, 6'd0},
    '{hntm_pkg::OP_QUERY, 6'd0,  5'd0,  "a",   1'b1, 6'd1,  1'b1, 1'b0, 6'd0}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        operation_i;
  logic [hntm_pkg::SLOT_W-1:0] entry_slot_i;
  logic [hntm_pkg::POS_W-1:0]  byte_pos_i;
  logic [hntm_pkg::BYTE_W-1:0] name_byte_i;
  logic                        last_byte_i;
  logic                        done_o;
  logic                        hit_o;
  logic [hntm_pkg::SLOT_W-1:0] match_slot_o;

  // keyword table mirror and the name scan in progress
  logic [hntm_pkg::BYTE_W-1:0] table_bytes [NUM_ENTRIES][MAX_LEN];
  logic [5:0]                  table_len   [NUM_ENTRIES];
  bit                          written     [NUM_ENTRIES][MAX_LEN];
  logic [NUM_ENTRIES-1:0]      alive;
  int unsigned                 scan_pos;

  match_result_t pending_matches [$];

  int  mismatches;
  int  items_sent;
  int  loads_sent;
  int  query_bytes_sent;
  int  names_due;
  int  hits_due;
  int  quiet_cycles;
  bit  idle_allowed;

  header_name_table_match_unit #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_LEN     (MAX_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .entry_slot_i (entry_slot_i),
    .byte_pos_i   (byte_pos_i),
    .name_byte_i  (name_byte_i),
    .last_byte_i  (last_byte_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .match_slot_o (match_slot_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // advance the table mirror by one request; a final name byte yields a match result
  task automatic step_matcher(input logic op, input logic [hntm_pkg::SLOT_W-1:0] slot,
                              input logic [hntm_pkg::POS_W-1:0] pos,
                              input logic [hntm_pkg::BYTE_W-1:0] nb,
                              input logic last, output bit produces,
                              output match_result_t res);
    logic [hntm_pkg::BYTE_W-1:0] t;
    bit                          same;
    produces = 1'b0;
    res      = '0;
    if (op == hntm_pkg::OP_LOAD) begin
      table_bytes[slot][pos] = nb;
      written[slot][pos]     = 1'b1;
      if (last) table_len[slot] = 6'(pos + 1);
      return;
    end
    if (scan_pos < MAX_LEN) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        if (alive[e]) begin
          if (scan_pos >= table_len[e]) begin
            alive[e] = 1'b0;
          end else begin
            t = table_bytes[e][scan_pos];
            // lowercase letters also accept the byte with the case bit cleared
            same = (t >= hntm_pkg::LOWER_A && t <= hntm_pkg::LOWER_Z) ?
                   ((nb | hntm_pkg::CASE_BIT) == t) : (nb == t);
            if (!same) alive[e] = 1'b0;
          end
        end
      end
      scan_pos++;
    end else begin
      alive = '0;
    end
    if (!last) return;
    produces = 1'b1;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (alive[e] && table_len[e] == scan_pos) begin
        res.hit  = 1'b1;
        res.slot = hntm_pkg::SLOT_W'(e);
        break;
      end
    end
    scan_pos = 0;
    alive    = '1;
  endtask

  // drive one request at the falling edge, wait for it to be taken, then predict
  task automatic send_request(input logic op, input logic [hntm_pkg::SLOT_W-1:0] slot,
                              input logic [hntm_pkg::POS_W-1:0] pos,
                              input logic [hntm_pkg::BYTE_W-1:0] nb,
                              input logic last, input bit pinned, input logic pin_hit,
                              input logic [hntm_pkg::SLOT_W-1:0] pin_slot);
    int            gap;
    bit            produces;
    match_result_t res;
    gap = (idle_allowed && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    entry_slot_i <= slot;
    byte_pos_i   <= pos;
    name_byte_i  <= nb;
    last_byte_i  <= last;
    do @(posedge clk_i); while (busy !== 1'b0);
    step_matcher(op, slot, pos, nb, last, produces, res);
    if (produces) begin
      if (pinned) begin
        res.hit  = pin_hit;
        res.slot = pin_slot;
      end
      pending_matches.push_back(res);
      names_due++;
      if (res.hit) hits_due++;
    end
    items_sent++;
    if (op == hntm_pkg::OP_LOAD) loads_sent++;
    else query_bytes_sent++;
  endtask

  // load at any slot and position; sets a length only when no unwritten byte falls inside it
  task automatic send_stray_load();
    logic [hntm_pkg::SLOT_W-1:0] slot;
    logic [hntm_pkg::POS_W-1:0]  pos;
    bit                          prefix_ok;
    slot      = hntm_pkg::SLOT_W'($urandom_range(0, NUM_ENTRIES - 1));
    pos       = hntm_pkg::POS_W'($urandom_range(0, MAX_LEN - 1));
    prefix_ok = 1'b1;
    for (int j = 0; j < pos; j++) if (!written[slot][j]) prefix_ok = 1'b0;
    send_request(hntm_pkg::OP_LOAD, slot, pos, hntm_pkg::BYTE_W'($urandom_range(0, 255)),
                 prefix_ok && ($urandom_range(0, 1) == 1), 1'b0, 1'b0, '0);
  endtask

  // random slot that holds a keyword, or -1 if the table is empty
  function automatic int pick_filled_slot();
    int first;
    first = $urandom_range(0, NUM_ENTRIES - 1);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (table_len[(first + i) % NUM_ENTRIES] != 0) return (first + i) % NUM_ENTRIES;
    end
    return -1;
  endfunction

  // mostly a narrow lowercase alphabet so keywords collide, sometimes any byte
  function automatic logic [hntm_pkg::BYTE_W-1:0] random_name_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return hntm_pkg::LOWER_A + hntm_pkg::BYTE_W'($urandom_range(0, 3));
    if (r < 9) return hntm_pkg::LOWER_A + hntm_pkg::BYTE_W'($urandom_range(0, 25));
    return hntm_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // result check
  always @(posedge clk_i) begin
    match_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result: hit %0b match_slot %0d", hit_o, match_slot_o);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0b, actual %0b", want.hit, hit_o);
          mismatches++;
        end
        if (match_slot_o !== want.slot) begin
          $error("match_slot: expected %0d, actual %0d", want.slot, match_slot_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [hntm_pkg::BYTE_W-1:0] word [$];
    logic [hntm_pkg::BYTE_W-1:0] t;
    int                          kind;
    int                          filled;
    int                          len;
    int                          slot;
    int                          window_end;
    bit                          window_idle;
    stim_row_t                   row;

    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = hntm_pkg::OP_LOAD;
    entry_slot_i = '0;
    byte_pos_i   = '0;
    name_byte_i  = '0;
    last_byte_i  = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    loads_sent   = 0;
    query_bytes_sent = 0;
    names_due    = 0;
    hits_due     = 0;
    quiet_cycles = 0;
    idle_allowed = 1'b1;
    window_end   = 0;
    window_idle  = 1'b0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      table_len[e] = '0;
      for (int p = 0; p < MAX_LEN; p++) begin
        table_bytes[e][p] = '0;
        written[e][p]     = 1'b0;
      end
    end
    alive    = '1;
    scan_pos = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      for (int k = 0; k < row.rep; k++) begin
        send_request(row.op, row.slot, row.pos, row.nbyte, row.last,
                     row.pinned && (k == row.rep - 1), row.exp_hit, row.exp_slot);
      end
    end

    // random keyword loads, names and stray loads
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= window_end) begin
        window_end  = items_sent + 30;
        window_idle = ($urandom_range(0, 1) == 1);
      end
      idle_allowed = window_idle && (items_sent < CALM_AFTER);
      kind = $urandom_range(0, 99);
      word.delete();
      if (kind < 35) begin
        // whole keyword, sometimes a copy of an existing one into another slot
        slot   = $urandom_range(0, NUM_ENTRIES - 1);
        filled = pick_filled_slot();
        if (filled >= 0 && $urandom_range(0, 9) < 3) begin
          for (int i = 0; i < table_len[filled]; i++) word.push_back(table_bytes[filled][i]);
        end else begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, MAX_LEN)
                                             : $urandom_range(1, 6);
          for (int i = 0; i < len; i++) word.push_back(random_name_byte());
        end
        for (int i = 0; i < word.size(); i++) begin
          send_request(hntm_pkg::OP_LOAD, hntm_pkg::SLOT_W'(slot), hntm_pkg::POS_W'(i),
                       word[i], i == word.size() - 1, 1'b0, 1'b0, '0);
        end
      end else if (kind < 45) begin
        send_stray_load();
      end else begin
        kind   = $urandom_range(0, 99);
        filled = pick_filled_slot();
        if (kind < 65 && filled >= 0) begin
          // a stored keyword with random case, now and then damaged
          for (int i = 0; i < table_len[filled]; i++) begin
            t = table_bytes[filled][i];
            if ((t >= hntm_pkg::LOWER_A && t <= hntm_pkg::LOWER_Z &&
                 $urandom_range(0, 1) == 1) ||
                $urandom_range(0, 19) == 0) t = t ^ hntm_pkg::CASE_BIT;
            word.push_back(t);
          end
          kind = $urandom_range(0, 99);
          if (kind < 10) begin
            len       = $urandom_range(0, word.size() - 1);
            word[len] = word[len] ^ hntm_pkg::BYTE_W'($urandom_range(1, 255));
          end else if (kind < 18 && word.size() > 1) begin
            void'(word.pop_back());
          end else if (kind < 26) begin
            word.push_back(random_name_byte());
          end
        end else if (kind < 92) begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            t = random_name_byte();
            word.push_back(($urandom_range(0, 1) == 1) ? t ^ hntm_pkg::CASE_BIT : t);
          end
        end else begin
          len = $urandom_range(MAX_LEN, MAX_LEN + 8);
          for (int i = 0; i < len; i++) word.push_back(random_name_byte());
        end
        for (int i = 0; i < word.size(); i++) begin
          if (i > 0 && $urandom_range(0, 9) == 0) send_stray_load();
          send_request(hntm_pkg::OP_QUERY,
                       hntm_pkg::SLOT_W'($urandom_range(0, NUM_ENTRIES - 1)),
                       hntm_pkg::POS_W'($urandom_range(0, MAX_LEN - 1)), word[i],
                       i == word.size() - 1, 1'b0, 1'b0, '0);
        end
      end
    end

    @(negedge clk_i);
    start <= 1'b0;

    // drain
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d table loads and %0d name bytes", loads_sent, query_bytes_sent);
    $display("checked %0d name results, %0d of them hits", names_due, hits_due);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
